@@ design/zbf_pkg.sv @@
package zbf_pkg;

	localparam int MODE_W  = 2;
	localparam int COORD_W = 7;
	localparam int DEPTH_W = 32;
	localparam int RGBA_W  = 32;
	localparam int DIM_W   = 8;
	// y * width + x for 7-bit coordinates and an 8-bit width
	localparam int CALC_AW = 15;
	localparam int COUNT_W = 2 * DIM_W;

	localparam logic [MODE_W-1:0] MODE_DEPTH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0]   DIM_RESET     = 8'd128;
	localparam logic [DEPTH_W-1:0] DEPTH_NEG_INF = 32'h8000_0000;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic                      oor;
		logic [CALC_AW-1:0]        addr;
		logic signed [DEPTH_W-1:0] depth;
		logic [RGBA_W-1:0]         rgba;
	} item_t;

	typedef struct packed {
		logic              depth_pass;
		logic              oor;
		logic [RGBA_W-1:0] rgba;
	} result_t;

endpackage

@@ design/z_buffered_framebuffer_core.sv @@
// Depth-tested framebuffer. Items wait in the 2-entry queue; a colour write or out-of-range item
// then loads the result register directly, a depth test or read-back goes through ST_EXEC, and a
// clear sweeps width*height pixels (one pixel per cycle). One write per cycle while the result is
// free; a depth test or read ends before the next item; a stalled result holds the back end, then
// the queue. Reset (arst_n low) clears control state; then a sweep over MAX_WIDTH*MAX_HEIGHT pixels
// zeroes colour and sets depth to minus infinity, with the input held off meanwhile.
module z_buffered_framebuffer_core import zbf_pkg::*; #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// x_coord[6:0], y_coord[13:7], depth[45:14], red[53:46], green[61:54],
	// blue[69:62], alpha[77:70], zero[79:78]
	input  logic [79:0]         s_axis_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]   s_axis_tuser,
	// result items
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// depth_pass[0], out_of_range[1], read_red[9:2], read_green[17:10],
	// read_blue[25:18], read_alpha[33:26], zero[39:34]
	output logic [39:0]         m_axis_tdata,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             reg_wr;

	logic             q_full, q_empty, push, pop;
	item_t            push_item, q_item;
	logic             init_busy;
	result_t          res;

	// --- register port: frame_width at 0x0, frame_height at 0x4 ---
	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_IDX_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_IDX_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IDX_WIDTH:  prdata = 32'(width_q);
			REG_IDX_HEIGHT: prdata = 32'(height_q);
			default:        prdata = '0;
		endcase
	end

	// --- frame size in use: zero acts as one, capped at the store size ---
	always_comb begin
		priority if (width_q == '0)
			w_eff = DIM_W'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = width_q;
	end

	always_comb begin
		priority if (height_q == '0)
			h_eff = DIM_W'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// front: bounds check and linear address, no items during the reset sweep
	zbf_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.enable        (~init_busy),
		.w_eff         (w_eff),
		.h_eff         (h_eff),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	zbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_item)
	);

	// back: pixel stores, depth compare, clear sweep and the result register
	zbf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.pop       (pop),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.init_busy (init_busy),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {6'b0, res.rgba, res.oor, res.depth_pass};

endmodule

@@ design/zbf_front.sv @@
module zbf_front import zbf_pkg::*; (
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [79:0]        s_axis_tdata,
	input  logic [MODE_W-1:0]  s_axis_tuser,
	input  logic               enable,
	input  logic [DIM_W-1:0]   w_eff,
	input  logic [DIM_W-1:0]   h_eff,
	input  logic               q_full,
	output logic               push,
	output item_t              push_item
);

	logic [COORD_W-1:0] x;
	logic [COORD_W-1:0] y;
	logic [CALC_AW-1:0] row_base;

	assign x = s_axis_tdata[6:0];
	assign y = s_axis_tdata[13:7];

	assign s_axis_tready = enable & ~q_full;
	assign push          = s_axis_tvalid & s_axis_tready;

	assign row_base = CALC_AW'(y) * CALC_AW'(w_eff);

	always_comb begin
		push_item.mode  = s_axis_tuser;
		// clear ignores coordinates altogether
		push_item.oor   = (s_axis_tuser != MODE_CLEAR) &&
			((DIM_W'(x) >= w_eff) || (DIM_W'(y) >= h_eff));
		push_item.addr  = row_base + CALC_AW'(x);
		push_item.depth = $signed(s_axis_tdata[45:14]);
		push_item.rgba  = s_axis_tdata[77:46];
	end

endmodule

@@ design/zbf_queue.sv @@
module zbf_queue import zbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t head
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	item_t          entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

@@ design/zbf_back.sv @@
module zbf_back import zbf_pkg::*; #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  item_t            q_item,
	output logic             pop,
	input  logic [DIM_W-1:0] w_eff,
	input  logic [DIM_W-1:0] h_eff,
	output logic             init_busy,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam int NUM_PIXELS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam logic [AW-1:0] LAST_PIXEL = AW'(NUM_PIXELS - 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;

	logic [RGBA_W-1:0]         color_mem [NUM_PIXELS];
	logic [DEPTH_W-1:0]        depth_mem [NUM_PIXELS];
	logic [RGBA_W-1:0]         color_rd_q;
	logic signed [DEPTH_W-1:0] depth_rd_q;

	logic [2:0]         state_q, state_d;
	logic [AW-1:0]      sweep_q, sweep_d;
	logic [COUNT_W-1:0] n_q, n_d;
	item_t              item_q, item_d;
	logic               res_valid_q;
	result_t            res_q, res_d;
	logic               res_load;
	logic               out_free;
	logic               pass;

	logic               we_color, we_depth;
	logic [AW-1:0]      waddr, raddr;
	logic [RGBA_W-1:0]  wcolor;
	logic [DEPTH_W-1:0] wdepth;

	assign out_free  = ~res_valid_q | res_ready;
	assign raddr     = AW'(q_item.addr);
	assign init_busy = (state_q == ST_INIT);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pass      = ($signed(item_q.depth) >= depth_rd_q);

	always_comb begin
		state_d  = state_q;
		sweep_d  = sweep_q;
		n_d      = n_q;
		item_d   = item_q;
		pop      = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		we_color = 1'b0;
		we_depth = 1'b0;
		waddr    = AW'(item_q.addr);
		wcolor   = item_q.rgba;
		wdepth   = item_q.depth;
		unique case (state_q)
			ST_INIT: begin
				we_color = 1'b1;
				we_depth = 1'b1;
				waddr    = sweep_q;
				wcolor   = '0;
				wdepth   = DEPTH_NEG_INF;
				sweep_d  = sweep_q + AW'(1);
				if (sweep_q == LAST_PIXEL) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty && out_free) begin
					pop    = 1'b1;
					item_d = q_item;
					priority if (q_item.mode == MODE_CLEAR) begin
						n_d     = COUNT_W'(w_eff) * COUNT_W'(h_eff);
						sweep_d = '0;
						state_d = ST_SWEEP;
					end else if (q_item.oor) begin
						res_load  = 1'b1;
						res_d.oor = 1'b1;
					end else if (q_item.mode == MODE_WRITE) begin
						we_color = 1'b1;
						waddr    = raddr;
						wcolor   = q_item.rgba;
						res_load = 1'b1;
					end else begin
						// depth test or read: data is back next cycle
						state_d = ST_EXEC;
					end
				end
			end
			ST_EXEC: begin
				res_load = 1'b1;
				if (item_q.mode == MODE_DEPTH) begin
					we_depth         = pass;
					res_d.depth_pass = pass;
				end else begin
					res_d.rgba = color_rd_q;
				end
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				we_color = 1'b1;
				we_depth = 1'b1;
				waddr    = sweep_q;
				wdepth   = DEPTH_NEG_INF;
				sweep_d  = sweep_q + AW'(1);
				if (sweep_q == AW'(n_q - COUNT_W'(1))) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		n_q    <= n_d;
		item_q <= item_d;
		if (res_load)
			res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (we_color)
			color_mem[waddr] <= wcolor;
		color_rd_q <= color_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_depth)
			depth_mem[waddr] <= wdepth;
		depth_rd_q <= $signed(depth_mem[raddr]);
	end

endmodule
